@@ hdl/abad_pkg.sv @@
// ----------------------------------------------------------------------------
// abad_pkg
// Shared constants for the arcade bus address decoder: memory sizes, op
// codes, register indexes, memory map bounds, sound selector and read source codes.
// ----------------------------------------------------------------------------
package abad_pkg;

  // program rom size in bytes, 1024 to 32768
  localparam int ROM_BYTES = 32768;
  localparam int ROM_AW    = $clog2(ROM_BYTES);
  localparam logic [16:0] ROM_LIMIT = 17'(ROM_BYTES);

  localparam int WORK_DEPTH   = 4096;
  localparam int VIDEO_DEPTH  = 2048;
  localparam int SPRITE_DEPTH = 256;
  localparam int WORK_AW      = $clog2(WORK_DEPTH);
  localparam int VIDEO_AW     = $clog2(VIDEO_DEPTH);
  localparam int SPRITE_AW    = $clog2(SPRITE_DEPTH);

  // bus operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // configuration register indexes
  localparam logic REG_DIP_A = 1'b0;
  localparam logic REG_DIP_B = 1'b1;

  localparam logic [7:0] DIP_A_RESET = 8'hdf;
  localparam logic [7:0] DIP_B_RESET = 8'hff;
  localparam logic [7:0] OPEN_BUS    = 8'hff;

  // memory map
  localparam logic [15:0] ROM_LAST    = 16'h7fff;
  localparam logic [15:0] BG_FIRST    = 16'h8000;
  localparam logic [15:0] BG_LAST     = 16'h87ff;
  localparam logic [15:0] FG_FIRST    = 16'h8800;
  localparam logic [15:0] FG_LAST     = 16'h8fff;
  localparam logic [15:0] SPR_FIRST   = 16'h9000;
  localparam logic [15:0] SPR_LAST    = 16'h90ff;
  localparam logic [15:0] FLIP_ADDR   = 16'h9800;
  localparam logic [15:0] SND1_ADDR   = 16'h9801;
  localparam logic [15:0] SND2_ADDR   = 16'h9802;
  localparam logic [15:0] PROT_ADDR   = 16'h9803;
  localparam logic [15:0] PORT_A_ADDR = 16'ha000;
  localparam logic [15:0] PORT_B_ADDR = 16'ha001;
  localparam logic [15:0] DIP_A_ADDR  = 16'ha002;
  localparam logic [15:0] DIP_B_ADDR  = 16'ha003;
  localparam logic [15:0] WORK_FIRST  = 16'he000;
  localparam logic [15:0] WORK_LAST   = 16'hefff;
  localparam logic [15:0] SX_FIRST    = 16'hf000;
  localparam logic [15:0] SX_LAST     = 16'hf7ff;
  localparam logic [15:0] SY_FIRST    = 16'hf800;
  localparam logic [15:0] SY_LAST     = 16'hffff;

  // sound chip selector
  localparam logic [1:0] SND_NONE  = 2'd0;
  localparam logic [1:0] SND_CHIP1 = 2'd1;
  localparam logic [1:0] SND_CHIP2 = 2'd2;

  // where the read byte comes from
  localparam logic [2:0] SRC_CONST  = 3'd0;
  localparam logic [2:0] SRC_ROM    = 3'd1;
  localparam logic [2:0] SRC_BG     = 3'd2;
  localparam logic [2:0] SRC_FG     = 3'd3;
  localparam logic [2:0] SRC_SPRITE = 3'd4;
  localparam logic [2:0] SRC_WORK   = 3'd5;

endpackage

@@ hdl/abad_ram.sv @@
// ----------------------------------------------------------------------------
// abad_ram
// Generic single-clock ram with one write port and one read port; the read
// data is registered and holds while the read enable is low.
// ----------------------------------------------------------------------------
module abad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/arcade_bus_address_decoder.sv @@
// ----------------------------------------------------------------------------
// arcade_bus_address_decoder
// Memory map of an 8-bit cpu bus: program rom, video, sprite and work rams,
// protection read, player ports, dip switches, flip and scroll registers
// and the two sound chip latches.
// ----------------------------------------------------------------------------
//   channel   direction  content
//   s_*       in         one bus access: op in tuser, address/data/hl/ports
//   m_*       out        one result per access: read byte, flip, scrolls, sound
//   cfg_*     in         dip switch writes, index 0 bank a, index 1 bank b
//
// one access per cycle while s_tready is high; a result leaves through the ram
// read register, then the output register
// after reset the video, sprite and work rams are cleared in a pass during
// which s_tready stays low; cfg writes are taken throughout
// a stalled output holds the ram read data and the stage before it, and
// s_tready drops outside the clearing pass only when both stages are full
// ----------------------------------------------------------------------------
module arcade_bus_address_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // address, write_data, cpu_hl, player_port_a, player_port_b
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data, flip_screen, scroll_x, scroll_y, sound_byte
  output logic [1:0]  m_tuser,   // sound_select
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [1:0]  op;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [15:0] cpu_hl;
  logic [7:0]  player_port_a;
  logic [7:0]  player_port_b;
  logic        accept;

  assign op            = s_tuser;
  assign address       = s_tdata[15:0];
  assign write_data    = s_tdata[23:16];
  assign cpu_hl        = s_tdata[39:24];
  assign player_port_a = s_tdata[47:40];
  assign player_port_b = s_tdata[55:48];
  assign accept        = s_tvalid & s_tready;

  // configuration
  logic [7:0] dip_a;
  logic [7:0] dip_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_a <= abad_pkg::DIP_A_RESET;
      dip_b <= abad_pkg::DIP_B_RESET;
    end else if (cfg_valid & cfg_ready) begin
      if (cfg_index == abad_pkg::REG_DIP_A) begin
        dip_a <= cfg_data;
      end else begin
        dip_b <= cfg_data;
      end
    end
  end

  // ram clearing pass after reset
  logic                         clearing;
  logic [abad_pkg::WORK_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // address decode
  logic       addr_in_rom;
  logic       hl_in_rom;
  logic [2:0] rd_src;
  logic [7:0] rd_const;
  logic       bg_we;
  logic       fg_we;
  logic       spr_we;
  logic       work_we;
  logic       flip_we;
  logic       sx_we;
  logic       sy_we;
  logic       rom_we;
  logic [1:0] snd_sel;
  logic [abad_pkg::ROM_AW-1:0] rom_raddr;

  assign addr_in_rom = {1'b0, address} < abad_pkg::ROM_LIMIT;
  assign hl_in_rom   = {1'b0, cpu_hl} < abad_pkg::ROM_LIMIT;
  assign rom_raddr   = (address <= abad_pkg::ROM_LAST) ? address[abad_pkg::ROM_AW-1:0]
                                                       : cpu_hl[abad_pkg::ROM_AW-1:0];

  always_comb begin
    rd_src   = abad_pkg::SRC_CONST;
    rd_const = abad_pkg::OPEN_BUS;
    if (op == abad_pkg::OP_READ) begin
      if (address <= abad_pkg::ROM_LAST) begin
        if (addr_in_rom) begin
          rd_src = abad_pkg::SRC_ROM;
        end
      end else if (address inside {[abad_pkg::BG_FIRST:abad_pkg::BG_LAST]}) begin
        rd_src = abad_pkg::SRC_BG;
      end else if (address inside {[abad_pkg::FG_FIRST:abad_pkg::FG_LAST]}) begin
        rd_src = abad_pkg::SRC_FG;
      end else if (address inside {[abad_pkg::SPR_FIRST:abad_pkg::SPR_LAST]}) begin
        rd_src = abad_pkg::SRC_SPRITE;
      end else if (address == abad_pkg::PROT_ADDR) begin
        if (hl_in_rom) begin
          rd_src = abad_pkg::SRC_ROM;
        end
      end else if (address == abad_pkg::PORT_A_ADDR) begin
        rd_const = player_port_a;
      end else if (address == abad_pkg::PORT_B_ADDR) begin
        rd_const = player_port_b;
      end else if (address == abad_pkg::DIP_A_ADDR) begin
        rd_const = dip_a;
      end else if (address == abad_pkg::DIP_B_ADDR) begin
        rd_const = dip_b;
      end else if (address inside {[abad_pkg::WORK_FIRST:abad_pkg::WORK_LAST]}) begin
        rd_src = abad_pkg::SRC_WORK;
      end
    end
  end

  always_comb begin
    bg_we   = 1'b0;
    fg_we   = 1'b0;
    spr_we  = 1'b0;
    work_we = 1'b0;
    flip_we = 1'b0;
    sx_we   = 1'b0;
    sy_we   = 1'b0;
    snd_sel = abad_pkg::SND_NONE;
    if (accept && op == abad_pkg::OP_WRITE) begin
      if (address inside {[abad_pkg::BG_FIRST:abad_pkg::BG_LAST]}) begin
        bg_we = 1'b1;
      end else if (address inside {[abad_pkg::FG_FIRST:abad_pkg::FG_LAST]}) begin
        fg_we = 1'b1;
      end else if (address inside {[abad_pkg::SPR_FIRST:abad_pkg::SPR_LAST]}) begin
        spr_we = 1'b1;
      end else if (address == abad_pkg::FLIP_ADDR) begin
        flip_we = 1'b1;
      end else if (address == abad_pkg::SND1_ADDR) begin
        snd_sel = abad_pkg::SND_CHIP1;
      end else if (address == abad_pkg::SND2_ADDR) begin
        snd_sel = abad_pkg::SND_CHIP2;
      end else if (address inside {[abad_pkg::WORK_FIRST:abad_pkg::WORK_LAST]}) begin
        work_we = 1'b1;
      end else if (address inside {[abad_pkg::SX_FIRST:abad_pkg::SX_LAST]}) begin
        sx_we = 1'b1;
      end else if (address inside {[abad_pkg::SY_FIRST:abad_pkg::SY_LAST]}) begin
        sy_we = 1'b1;
      end
    end
  end

  assign rom_we = accept && op == abad_pkg::OP_LOAD && addr_in_rom;

  // memories; the clearing pass owns the video, sprite and work ram write ports until it ends
  logic [7:0] rom_rdata;
  logic [7:0] bg_rdata;
  logic [7:0] fg_rdata;
  logic [7:0] spr_rdata;
  logic [7:0] work_rdata;
  logic [7:0] ram_wdata;

  assign ram_wdata = clearing ? 8'h00 : write_data;

  abad_ram #(.WIDTH(8), .DEPTH(abad_pkg::ROM_BYTES)) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (address[abad_pkg::ROM_AW-1:0]),
    .wdata (write_data),
    .re    (accept),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  abad_ram #(.WIDTH(8), .DEPTH(abad_pkg::VIDEO_DEPTH)) u_bg_ram (
    .clk   (clk),
    .we    (clearing | bg_we),
    .waddr (clearing ? clr_addr[abad_pkg::VIDEO_AW-1:0] : address[abad_pkg::VIDEO_AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (address[abad_pkg::VIDEO_AW-1:0]),
    .rdata (bg_rdata)
  );

  abad_ram #(.WIDTH(8), .DEPTH(abad_pkg::VIDEO_DEPTH)) u_fg_ram (
    .clk   (clk),
    .we    (clearing | fg_we),
    .waddr (clearing ? clr_addr[abad_pkg::VIDEO_AW-1:0] : address[abad_pkg::VIDEO_AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (address[abad_pkg::VIDEO_AW-1:0]),
    .rdata (fg_rdata)
  );

  abad_ram #(.WIDTH(8), .DEPTH(abad_pkg::SPRITE_DEPTH)) u_sprite_ram (
    .clk   (clk),
    .we    (clearing | spr_we),
    .waddr (clearing ? clr_addr[abad_pkg::SPRITE_AW-1:0] : address[abad_pkg::SPRITE_AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (address[abad_pkg::SPRITE_AW-1:0]),
    .rdata (spr_rdata)
  );

  abad_ram #(.WIDTH(8), .DEPTH(abad_pkg::WORK_DEPTH)) u_work_ram (
    .clk   (clk),
    .we    (clearing | work_we),
    .waddr (clearing ? clr_addr : address[abad_pkg::WORK_AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (address[abad_pkg::WORK_AW-1:0]),
    .rdata (work_rdata)
  );

  // video control registers
  logic       flip;
  logic [7:0] scroll_x;
  logic [7:0] scroll_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      flip     <= 1'b0;
      scroll_x <= 8'h00;
      scroll_y <= 8'h00;
    end else begin
      if (flip_we) begin
        flip <= write_data[0];
      end
      if (sx_we) begin
        scroll_x <= write_data;
      end
      if (sy_we) begin
        scroll_y <= write_data;
      end
    end
  end

  // stage 1: waits on the ram read register
  logic       s1_valid;
  logic [2:0] s1_src;
  logic [7:0] s1_const;
  logic [1:0] s1_snd_sel;
  logic [7:0] s1_snd_byte;
  logic       m_load;
  logic [7:0] read_data_next;

  assign m_load   = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~clearing & (~s1_valid | m_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (m_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src      <= rd_src;
      s1_const    <= rd_const;
      s1_snd_sel  <= snd_sel;
      s1_snd_byte <= (snd_sel != abad_pkg::SND_NONE) ? write_data : 8'h00;
    end
  end

  always_comb begin
    case (s1_src)
      abad_pkg::SRC_ROM:    read_data_next = rom_rdata;
      abad_pkg::SRC_BG:     read_data_next = bg_rdata;
      abad_pkg::SRC_FG:     read_data_next = fg_rdata;
      abad_pkg::SRC_SPRITE: read_data_next = spr_rdata;
      abad_pkg::SRC_WORK:   read_data_next = work_rdata;
      default:              read_data_next = s1_const;
    endcase
  end

  // output register; flip and scroll already reflect the stage 1 beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= {7'd0, s1_snd_byte, scroll_y, scroll_x, flip, read_data_next};
      m_tuser <= s1_snd_sel;
    end
  end

endmodule
